>>> rtl/rdsa_pkg.sv
// Package for the range DFA string acceptor.
// Holds the word kind codes, the edge slot layout and the edge pick result.
// No dependencies.
package rdsa_pkg;

  localparam int unsigned STATE_W = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned KIND_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_EDGE   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  // One edge slot as stored in a table row.
  typedef struct packed {
    logic               valid;
    logic [BYTE_W-1:0]  lo;
    logic [BYTE_W-1:0]  hi;
    logic [STATE_W-1:0] target;
  } edge_t;

  localparam int unsigned EDGE_W = $bits(edge_t);

  // Outcome of the edge search for one data byte.
  typedef struct packed {
    logic               hit;
    logic [STATE_W-1:0] target;
  } pick_t;

endpackage

>>> rtl/rdsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the state table of the range DFA string acceptor; no dependencies.
module rdsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rdsa_pick.sv
// Edge selector: among the valid edges of one table row whose signed range
// holds the byte, pick the narrowest, lowest slot on a tie. Uses rdsa_pkg.
module rdsa_pick
  import rdsa_pkg::*;
#(
  parameter int unsigned EDGES_PER_STATE = 8
) (
  input  logic [EDGES_PER_STATE*EDGE_W-1:0] row_i,
  input  logic [BYTE_W-1:0]                 byte_i,
  output pick_t                             pick_o
);

  always_comb begin
    edge_t             e;
    logic [BYTE_W-1:0] span;
    logic [BYTE_W-1:0] best;
    logic              hit;
    logic [STATE_W-1:0] tgt;
    best = '0;
    hit  = 1'b0;
    tgt  = '0;
    for (int i = 0; i < EDGES_PER_STATE; i++) begin
      e    = edge_t'(row_i[i*EDGE_W +: EDGE_W]);
      span = BYTE_W'(e.hi - e.lo);
      // strict compare keeps the lower slot on a tie
      if (e.valid && ($signed(byte_i) >= $signed(e.lo)) &&
          ($signed(byte_i) <= $signed(e.hi)) && (!hit || (span < best))) begin
        hit  = 1'b1;
        best = span;
        tgt  = e.target;
      end
    end
    pick_o.hit    = hit;
    pick_o.target = tgt;
  end

endmodule

>>> rtl/range_dfa_string_acceptor.sv
// Top level of the range DFA string acceptor.
// Depends on rdsa_pkg, rdsa_ram (state table) and rdsa_pick (edge selector).
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one word per handshake.
//   kind_i selects the word: edge slot write, accept bit write, data byte or
//   end of string. Only the end-of-string word produces an output word on
//   the output channel (out_valid_o / out_ready_i): accepted, failed flag
//   and final state. The start state is written through cfg_we_i /
//   cfg_wdata_i, which also abandons any string in progress.
//
// Timing: the cycle that accepts a word (IDLE) issues the read of the
//   state's table row (edges and accept bit) on the table memory port;
//   EXEC then compares all edges of the row in parallel, or modifies and
//   writes the row back for load words. The next word is taken only back
//   in IDLE, so no new word is accepted while one is in EXEC.
//   out_valid_o is registered and rises after the EXEC state of the end word.
// Stall: the result sits in an output register; input words keep flowing
//   while it waits. An end word that finds the register still full holds in
//   EXEC until the receiver takes the earlier result.
// Reset: all table rows read as empty (per-row valid flops), accept bits
//   zero, start state 0, no failure. No clearing pass is needed.
module range_dfa_string_acceptor
  import rdsa_pkg::*;
#(
  parameter int unsigned NUM_STATES      = 64,
  parameter int unsigned EDGES_PER_STATE = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // start state register
  input  logic               cfg_we_i,
  input  logic [STATE_W-1:0] cfg_wdata_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [STATE_W-1:0] state_index_i,
  input  logic [SLOT_W-1:0]  edge_slot_i,
  input  logic signed [BYTE_W-1:0] low_bound_i,
  input  logic signed [BYTE_W-1:0] high_bound_i,
  input  logic [STATE_W-1:0] target_state_i,
  input  logic               edge_enable_i,
  input  logic               accept_value_i,
  input  logic signed [BYTE_W-1:0] data_byte_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o,
  output logic               transition_failed_o,
  output logic [STATE_W-1:0] final_state_o
);

  localparam int unsigned AW     = $clog2(NUM_STATES);
  localparam int unsigned SW     = (EDGES_PER_STATE > 1) ? $clog2(EDGES_PER_STATE) : 1;
  localparam int unsigned EDGES_W = EDGES_PER_STATE * EDGE_W;
  localparam int unsigned ROW_W  = EDGES_W + 1;   // accept bit on top
  localparam int unsigned CMP_W  = 9;             // holds NUM_STATES up to 511

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e             state_q;
  logic [STATE_W-1:0] cur_q;
  logic               dead_q;
  logic [STATE_W-1:0] start_q;
  logic [NUM_STATES-1:0] row_vld_q;
  logic               out_valid_q;
  logic               accepted_q;
  logic               failed_q;
  logic [STATE_W-1:0] final_q;

  // word captured at accept
  kind_e              kind_q;
  logic [AW-1:0]      addr_q;
  logic               inrange_q;
  logic [SW-1:0]      slot_q;
  edge_t              edge_q;
  logic               accval_q;
  logic [BYTE_W-1:0]  byte_q;

  logic               in_fire;
  kind_e              kind_in;
  logic               load_in;
  logic [AW-1:0]      raddr;
  logic               inrange_in;
  logic [ROW_W-1:0]   rdata;
  logic [ROW_W-1:0]   base_row;
  logic [ROW_W-1:0]   new_row;
  logic               ram_we;
  logic               out_free;
  pick_t              pick;

  assign kind_in = kind_e'(kind_i);
  assign load_in = (kind_in == KIND_EDGE) || (kind_in == KIND_ACCEPT);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Load words address the written state, data and end words the current one.
  always_comb begin
    raddr      = load_in ? AW'(state_index_i) : AW'(cur_q);
    inrange_in = 1'b0;
    case (kind_in)
      KIND_EDGE: begin
        inrange_in = (CMP_W'(state_index_i) < CMP_W'(NUM_STATES)) &&
                     (CMP_W'(edge_slot_i) < CMP_W'(EDGES_PER_STATE));
      end
      KIND_ACCEPT: begin
        inrange_in = (CMP_W'(state_index_i) < CMP_W'(NUM_STATES));
      end
      KIND_DATA, KIND_END: begin
        inrange_in = (CMP_W'(cur_q) < CMP_W'(NUM_STATES));
      end
      default: begin
        inrange_in = 1'b0;
      end
    endcase
  end

  rdsa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_STATES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (new_row),
    .re_i    (in_fire),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // A row never written reads as empty: no valid edges, accept bit clear.
  assign base_row = (inrange_q && row_vld_q[addr_q]) ? rdata : '0;

  always_comb begin
    new_row = base_row;
    if (kind_q == KIND_EDGE) begin
      new_row[slot_q*EDGE_W +: EDGE_W] = edge_q;
    end else begin
      new_row[ROW_W-1] = accval_q;
    end
  end

  assign ram_we = (state_q == ST_EXEC) && inrange_q &&
                  ((kind_q == KIND_EDGE) || (kind_q == KIND_ACCEPT));

  rdsa_pick #(
    .EDGES_PER_STATE (EDGES_PER_STATE)
  ) u_pick (
    .row_i  (base_row[EDGES_W-1:0]),
    .byte_i (byte_q),
    .pick_o (pick)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // Word payload: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q        <= kind_in;
      addr_q        <= raddr;
      slot_q        <= SW'(edge_slot_i);
      edge_q.valid  <= edge_enable_i;
      edge_q.lo     <= low_bound_i;
      edge_q.hi     <= high_bound_i;
      edge_q.target <= target_state_i;
      accval_q      <= accept_value_i;
      byte_q        <= data_byte_i;
    end
  end

  // Control state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      dead_q      <= 1'b0;
      start_q     <= '0;
      row_vld_q   <= '0;
      inrange_q   <= 1'b0;
      out_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
      failed_q    <= 1'b0;
      final_q     <= '0;
    end else begin
      // drop the result once taken
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            inrange_q <= inrange_in;
            state_q   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (kind_q)
            KIND_EDGE, KIND_ACCEPT: begin
              if (inrange_q) begin
                row_vld_q[addr_q] <= 1'b1;
              end
              state_q <= ST_IDLE;
            end
            KIND_DATA: begin
              // advance along the picked edge, or fail and freeze
              if (!dead_q) begin
                if (inrange_q && pick.hit) begin
                  cur_q <= pick.target;
                end else begin
                  dead_q <= 1'b1;
                end
              end
              state_q <= ST_IDLE;
            end
            KIND_END: begin
              // hold until the output register is free
              if (out_free) begin
                out_valid_q <= 1'b1;
                accepted_q  <= !dead_q && base_row[ROW_W-1];
                failed_q    <= dead_q;
                final_q     <= cur_q;
                cur_q       <= start_q;
                dead_q      <= 1'b0;
                state_q     <= ST_IDLE;
              end
            end
            default: begin
              state_q <= ST_IDLE;
            end
          endcase
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      // start state write restarts the string
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
        cur_q   <= cfg_wdata_i;
        dead_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign accepted_o          = accepted_q;
  assign transition_failed_o = failed_q;
  assign final_state_o       = final_q;

  // A result appears only after the EXEC state of an end word.
  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC && kind_q == KIND_END))
    else $error("result word without end-of-string word");

  // Delivering an end word returns to the start state with no failure.
  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && kind_q == KIND_END && out_free && !cfg_we_i)
    |=> (cur_q == start_q && !dead_q))
    else $error("end word did not restart the automaton");

  // Failure sticks until an end word or a start state write.
  a_dead_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dead_q && !cfg_we_i && !(state_q == ST_EXEC && kind_q == KIND_END))
    |=> dead_q)
    else $error("failure flag cleared mid-string");

  // Words other than end of string never hold in EXEC; they go back to IDLE.
  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && kind_q != KIND_END) |=> (state_q == ST_IDLE))
    else $error("load or data word held in execute");

endmodule
